// ===== sv/srbc_pkg.sv =====
// Package for the sparse binary row compare core: sizes, item kind codes
// and the request structs passed between the core's units.
// No dependencies; every other file uses it by scoped names.
package srbc_pkg;

  // Column store geometry and row tag width.
  localparam int COLUMNS  = 4096;
  localparam int TAG_BITS = 16;
  localparam int ADDR_W   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  // Fixed field widths of the stream items.
  localparam int COL_W      = 12;
  localparam int KIND_W     = 2;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 216;

  typedef logic [TAG_BITS-1:0] tag_t;
  typedef logic [ADDR_W-1:0]   addr_t;

  localparam tag_t TAG_MAX = {TAG_BITS{1'b1}};
  localparam tag_t TAG_ONE = tag_t'(1);

  // Item kind codes carried on in_tuser.
  localparam logic [KIND_W-1:0] KIND_APPROX = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ORIG   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END    = 2'd2;

  // Request to the mark store: one read and one write port plus a clear trigger.
  typedef struct packed {
    logic  rd_en;
    addr_t rd_addr;
    logic  wr_en;
    addr_t wr_addr;
    tag_t  wr_data;
    logic  clear;
  } mst_req_t;

  // Per-item update to the statistics unit.
  typedef struct packed {
    logic inc_b;
    logic inc_a;
    logic inc_m;
    logic row_end;
  } st_upd_t;

endpackage

// ===== sv/srbc_mark_store.sv =====
// Column mark store of the row compare core: one tag per column in a
// synchronous memory with registered read data and a sweeping clear.
// Depends on srbc_pkg.
module srbc_mark_store (
  input  logic              clk,
  input  logic              rst_n,
  input  srbc_pkg::mst_req_t req,
  output srbc_pkg::tag_t    rd_data,
  output logic              busy
);

  srbc_pkg::tag_t  mem [srbc_pkg::COLUMNS];
  srbc_pkg::tag_t  rd_data_r;
  logic            clr_busy_r, clr_busy_nxt;
  srbc_pkg::addr_t clr_ptr_r, clr_ptr_nxt;
  logic            clr_last;

  assign clr_last = (clr_ptr_r == srbc_pkg::addr_t'(srbc_pkg::COLUMNS - 1));

  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_ptr_nxt  = clr_ptr_r;
    if (clr_busy_r) begin
      clr_ptr_nxt = clr_ptr_r + srbc_pkg::addr_t'(1);
      if (clr_last) begin
        clr_busy_nxt = 1'b0;
        clr_ptr_nxt  = '0;
      end
    end else if (req.clear) begin
      clr_busy_nxt = 1'b1;
      clr_ptr_nxt  = '0;
    end
  end

  // A reset starts a full sweep, since the memory itself has no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_ptr_r  <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_ptr_r  <= clr_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_ptr_r] <= '0;
    end else if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = clr_busy_r;

endmodule

// ===== sv/srbc_stats.sv =====
// Row and running-total counters of the row compare core, with the result
// register that drives the output channel.  Depends on srbc_pkg.
module srbc_stats (
  input  logic                                clk,
  input  logic                                rst_n,
  input  srbc_pkg::st_upd_t                   upd,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [srbc_pkg::OUT_DATA_W-1:0]     out_tdata
);

  logic [15:0] row_m_r, row_m_nxt;
  logic [15:0] row_a_r, row_a_nxt;
  logic [15:0] row_b_r, row_b_nxt;
  logic [31:0] sum_m_r, sum_m_nxt;
  logic [31:0] sum_a_r, sum_a_nxt;
  logic [31:0] sum_b_r, sum_b_nxt;
  logic [15:0] rows_r,  rows_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [srbc_pkg::OUT_DATA_W-1:0] out_data_r;

  logic [32:0] add_m, add_a, add_b;
  logic [16:0] row_pos, row_neg, row_dist;
  logic [33:0] tot_pos, tot_neg, tot_diff;
  logic [31:0] tot_err;

  // Saturating 32-bit totals including the row that ends now.
  assign add_m     = {1'b0, sum_m_r} + {17'd0, row_m_r};
  assign add_a     = {1'b0, sum_a_r} + {17'd0, row_a_r};
  assign add_b     = {1'b0, sum_b_r} + {17'd0, row_b_r};
  assign sum_m_nxt = add_m[32] ? 32'hFFFF_FFFF : add_m[31:0];
  assign sum_a_nxt = add_a[32] ? 32'hFFFF_FFFF : add_a[31:0];
  assign sum_b_nxt = add_b[32] ? 32'hFFFF_FFFF : add_b[31:0];
  assign rows_nxt  = (rows_r == 16'hFFFF) ? rows_r : rows_r + 16'd1;

  // Distances clamp at zero, since repeated original columns can match twice.
  assign row_pos  = {1'b0, row_a_r} + {1'b0, row_b_r};
  assign row_neg  = {row_m_r, 1'b0};
  assign row_dist = (row_neg >= row_pos) ? 17'd0 : row_pos - row_neg;

  assign tot_pos  = {2'b00, sum_a_nxt} + {2'b00, sum_b_nxt};
  assign tot_neg  = {1'b0, sum_m_nxt, 1'b0};
  assign tot_diff = tot_pos - tot_neg;
  assign tot_err  = (tot_neg >= tot_pos) ? 32'd0 :
                    ((tot_diff[33:32] != 2'b00) ? 32'hFFFF_FFFF : tot_diff[31:0]);

  always_comb begin
    row_m_nxt = row_m_r;
    row_a_nxt = row_a_r;
    row_b_nxt = row_b_r;
    if (upd.row_end) begin
      row_m_nxt = '0;
      row_a_nxt = '0;
      row_b_nxt = '0;
    end else begin
      if (upd.inc_m && row_m_r != 16'hFFFF) row_m_nxt = row_m_r + 16'd1;
      if (upd.inc_a && row_a_r != 16'hFFFF) row_a_nxt = row_a_r + 16'd1;
      if (upd.inc_b && row_b_r != 16'hFFFF) row_b_nxt = row_b_r + 16'd1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (upd.row_end) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_m_r     <= '0;
      row_a_r     <= '0;
      row_b_r     <= '0;
      sum_m_r     <= '0;
      sum_a_r     <= '0;
      sum_b_r     <= '0;
      rows_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      row_m_r     <= row_m_nxt;
      row_a_r     <= row_a_nxt;
      row_b_r     <= row_b_nxt;
      out_valid_r <= out_valid_nxt;
      if (upd.row_end) begin
        sum_m_r <= sum_m_nxt;
        sum_a_r <= sum_a_nxt;
        sum_b_r <= sum_b_nxt;
        rows_r  <= rows_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd.row_end) begin
      out_data_r <= {7'd0, rows_nxt, tot_err, sum_b_nxt, sum_a_nxt, sum_m_nxt,
                     row_dist, row_b_r, row_a_r, row_m_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== sv/sparse_binary_row_compare_core.sv =====
// Top level of the sparse binary row compare core: input stage, mark store
// read-compare-write control with forwarding, and the statistics unit.
// Depends on srbc_pkg, srbc_mark_store and srbc_stats.
//
// Usage: each input item carries a kind on in_tuser and a column on in_tdata.
// For every row, send the approximation row's columns (kind 0), then the
// original row's columns (kind 1), then one end-of-row item (kind 2). Kind 3
// items are accepted and dropped. Each end-of-row item yields one result item
// on the out_ channel with the row's match and entry counts, its distance,
// the saturating running totals, the total error and the finished row count.
// Throughput is one item per cycle while in_tready is high. A result enters
// the output register, which drives out_tvalid, as its end-of-row item
// leaves the execution stage; the item waits there while an earlier result
// still waits unread. The mark store takes one column per cycle: a read at
// accept, a compare and write in the next cycle, and a forward when an
// original column follows an approximation column of the same address. When
// the output register holds an unread result, column items still flow; only
// a further end-of-row item waits, and in_tready drops until out_tready frees
// the register. After reset, and again whenever the row tag wraps (every 65535
// rows), the store is swept clear one column per cycle with in_tready low.
module sparse_binary_row_compare_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [11:0] column, [15:12] zero
  input  logic [srbc_pkg::IN_DATA_W-1:0]      in_tdata,
  // [1:0] kind
  input  logic [srbc_pkg::KIND_W-1:0]         in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [15:0] row_match, [31:16] row_a_count, [47:32] row_b_count,
  // [64:48] row_distance, [96:65] total_match, [128:97] total_a_count,
  // [160:129] total_b_count, [192:161] total_error, [208:193] rows_done,
  // [215:209] zero
  output logic [srbc_pkg::OUT_DATA_W-1:0]     out_tdata
);

  // Execution stage: the accepted item, waiting for its registered read data.
  logic                          s1_valid_r, s1_valid_nxt;
  logic [srbc_pkg::KIND_W-1:0]   s1_kind_r;
  srbc_pkg::addr_t               s1_addr_r;
  logic                          s1_col_ok_r;
  logic                          s1_fwd_r;
  srbc_pkg::tag_t                tag_r, tag_nxt;

  logic                          accept;
  logic                          col_ok;
  srbc_pkg::addr_t               in_addr;
  logic                          s1_is_end;
  logic                          s1_stall;
  logic                          s1_commit;
  logic                          s1_wrap;
  logic                          hit;
  logic                          store_busy;
  srbc_pkg::tag_t                rd_data;
  srbc_pkg::mst_req_t            mst_req;
  srbc_pkg::st_upd_t             st_upd;

  assign in_addr = srbc_pkg::addr_t'(in_tdata[srbc_pkg::COL_W-1:0]);
  assign col_ok  = (32'(in_tdata[srbc_pkg::COL_W-1:0]) < 32'(srbc_pkg::COLUMNS));

  // An end-of-row item can only leave when the result register is free.
  assign s1_is_end = (s1_kind_r == srbc_pkg::KIND_END);
  assign s1_stall  = s1_valid_r && s1_is_end && out_tvalid && !out_tready;
  assign s1_commit = s1_valid_r && !s1_stall;
  // The row that wraps the tag holds off new items so the sweep sees no reads.
  assign s1_wrap   = s1_valid_r && s1_is_end && (tag_r == srbc_pkg::TAG_MAX);

  assign in_tready = !store_busy && !s1_stall && !s1_wrap;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    mst_req.rd_en   = accept;
    mst_req.rd_addr = in_addr;
    mst_req.wr_en   = s1_commit && (s1_kind_r == srbc_pkg::KIND_APPROX) && s1_col_ok_r;
    mst_req.wr_addr = s1_addr_r;
    mst_req.wr_data = tag_r;
    mst_req.clear   = s1_commit && s1_wrap;
  end

  // A write in the same cycle as the read of its address bypasses the memory;
  // the tag cannot change between the two items, so a forward is a hit.
  assign hit = s1_col_ok_r && (s1_fwd_r || (rd_data == tag_r));

  always_comb begin
    st_upd.inc_b   = s1_commit && (s1_kind_r == srbc_pkg::KIND_APPROX);
    st_upd.inc_a   = s1_commit && (s1_kind_r == srbc_pkg::KIND_ORIG);
    st_upd.inc_m   = s1_commit && (s1_kind_r == srbc_pkg::KIND_ORIG) && hit;
    st_upd.row_end = s1_commit && s1_is_end;
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_commit) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    tag_nxt = tag_r;
    if (s1_commit && s1_is_end) begin
      tag_nxt = s1_wrap ? srbc_pkg::TAG_ONE : tag_r + srbc_pkg::TAG_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      tag_r      <= srbc_pkg::TAG_ONE;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      tag_r      <= tag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind_r   <= in_tuser;
      s1_addr_r   <= in_addr;
      s1_col_ok_r <= col_ok;
      s1_fwd_r    <= mst_req.wr_en && (mst_req.wr_addr == in_addr);
    end
  end

  srbc_mark_store u_mark_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mst_req),
    .rd_data (rd_data),
    .busy    (store_busy)
  );

  srbc_stats u_stats (
    .clk        (clk),
    .rst_n      (rst_n),
    .upd        (st_upd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
